// ===== rtl/core/rrqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared widths, event codes, slot status codes and the ready queue control
// type of the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int SLOT_W    = 4;
  localparam int QUANT_W   = 16;
  localparam int COUNT_W   = 5;
  localparam int KIND_W    = 3;
  localparam int MAX_SLOTS = 16;

  localparam logic [QUANT_W-1:0] RESET_QUANTUM = 16'd10;

  // Event codes.
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_YIELD   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BLOCK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNBLOCK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SETQ    = 3'd4;

  // Slot status codes.
  localparam logic [1:0] SLOT_RUNNING = 2'd0;
  localparam logic [1:0] SLOT_QUEUED  = 2'd1;
  localparam logic [1:0] SLOT_PARKED  = 2'd2;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] slot;
  } qctl_t;

endpackage

// ===== rtl/core/rrqs_cell.sv =====
// ----------------------------------------------------------------------------
// rrqs_cell
// One entry of the shifting ready queue: holds a slot number, takes its upper
// neighbour's entry on a pop, or loads the pushed slot.
// ----------------------------------------------------------------------------
module rrqs_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic                        load,
  input  logic [rrqs_pkg::SLOT_W-1:0] up_slot,
  input  logic [rrqs_pkg::SLOT_W-1:0] load_slot,
  output logic [rrqs_pkg::SLOT_W-1:0] slot
);
  import rrqs_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= load_slot;
    end else if (shift) begin
      slot <= up_slot;
    end
  end

endmodule

// ===== rtl/core/rrqs_queue.sv =====
// ----------------------------------------------------------------------------
// rrqs_queue
// FIFO ready queue built as a row of cells. The head sits in cell 0; a pop
// moves every entry one cell down, and a push loads the first free cell.
// ----------------------------------------------------------------------------
module rrqs_queue #(
  parameter int NSLOT = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rrqs_pkg::qctl_t                     ctl,
  output logic [rrqs_pkg::SLOT_W-1:0]         head,
  output logic [$clog2(NSLOT+1)-1:0]          count,
  output logic                                full
);
  import rrqs_pkg::*;

  localparam int CNT_W = $clog2(NSLOT + 1);

  logic [SLOT_W-1:0] slots [NSLOT];
  logic [CNT_W-1:0]  wr_pos;
  logic [CNT_W-1:0]  count_next;
  logic              push_ok;

  assign full   = (count == CNT_W'(NSLOT));
  // With a pop in the same transfer the free cell is one lower.
  assign wr_pos = ctl.pop ? count - CNT_W'(1) : count;
  assign push_ok = ctl.push && (ctl.pop || !full);

  genvar i;
  generate
    for (i = 0; i < NSLOT; i++) begin : g_cell
      logic [SLOT_W-1:0] up;
      if (i == NSLOT - 1) begin : g_last
        assign up = '0;
      end else begin : g_mid
        assign up = slots[i+1];
      end
      rrqs_cell u_cell (
        .clk       (clk),
        .shift     (ctl.pop),
        .load      (push_ok && (wr_pos == CNT_W'(i))),
        .up_slot   (up),
        .load_slot (ctl.slot),
        .slot      (slots[i])
      );
    end
  endgenerate

  assign head = slots[0];

  always_comb begin
    count_next = count;
    if (push_ok && !ctl.pop) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop && !ctl.push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/round_robin_quantum_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_top
// Round-robin task scheduler with a per-slot time quantum and a shifting
// ready queue.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  event     start / busy           kind, task_req, quantum
//  config    cfg_valid / cfg_ready  cfg_data (idle slot)
//  result    done (one-cycle pulse) running_task, remaining, switched,
//                                   rejected, ready_count
//
// The result of an event is strobed on done in the cycle after it is taken;
// a new event may be taken every cycle. The queue, status and quantum table
// all update in the cycle the event is taken, so the update of the cell row
// sets the rate. busy is held high by rst and clears once rst has fallen.
// The result cannot be stalled.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_top #(
  parameter int MAX_TASKS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rrqs_pkg::KIND_W-1:0]   kind,
  input  logic [rrqs_pkg::SLOT_W-1:0]   task_req,
  input  logic [rrqs_pkg::QUANT_W-1:0]  quantum,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rrqs_pkg::SLOT_W-1:0]   cfg_data,
  output logic                          done,
  output logic [rrqs_pkg::SLOT_W-1:0]   running_task,
  output logic [rrqs_pkg::QUANT_W-1:0]  remaining,
  output logic                          switched,
  output logic                          rejected,
  output logic [rrqs_pkg::COUNT_W-1:0]  ready_count
);
  import rrqs_pkg::*;

  localparam int NSLOT = (MAX_TASKS < MAX_SLOTS) ? MAX_TASKS : MAX_SLOTS;
  localparam int IDX_W = $clog2(NSLOT);
  localparam int CNT_W = $clog2(NSLOT + 1);

  logic [SLOT_W-1:0]  idle_slot;
  logic [SLOT_W-1:0]  running_slot;
  logic [SLOT_W-1:0]  running_slot_next;
  logic [QUANT_W-1:0] countdown;
  logic [QUANT_W-1:0] countdown_next;
  logic [1:0]         status      [NSLOT];
  logic [1:0]         status_next [NSLOT];
  logic [QUANT_W-1:0] qtab        [NSLOT];
  logic [QUANT_W-1:0] qtab_next   [NSLOT];

  qctl_t             qctl;
  logic [SLOT_W-1:0] head_slot;
  logic [CNT_W-1:0]  q_count;
  logic              q_full;

  logic              accept;
  logic              nonempty;
  logic              req_ok;
  logic              idle_ok;
  logic [SLOT_W-1:0] idle_eff;
  logic              expire;
  logic              req_blocked;
  logic [SLOT_W-1:0] next_slot;
  logic              run;
  logic              reload;
  logic              cd_dec;
  logic              rej;
  logic              sw;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign nonempty  = (q_count != '0);
  assign req_ok    = ({1'b0, task_req} < (SLOT_W + 1)'(NSLOT));
  assign idle_ok   = ({1'b0, idle_slot} < (SLOT_W + 1)'(NSLOT));
  assign idle_eff  = idle_ok ? idle_slot : '0;
  // A countdown already at zero counts as expiring too.
  assign expire    = (countdown <= QUANT_W'(1));
  assign req_blocked = req_ok && (status[task_req[IDX_W-1:0]] == SLOT_PARKED);

  rrqs_queue #(
    .NSLOT (NSLOT)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (qctl),
    .head  (head_slot),
    .count (q_count),
    .full  (q_full)
  );

  always_comb begin
    qctl        = '0;
    qctl.slot   = running_slot;
    next_slot   = running_slot;
    run         = 1'b0;
    reload      = 1'b0;
    cd_dec      = 1'b0;
    rej         = 1'b0;
    status_next = status;
    qtab_next   = qtab;
    if (accept) begin
      case (kind)
        KIND_TICK: begin
          if (!expire) begin
            cd_dec = 1'b1;
          end else begin
            reload = 1'b1;
            if (nonempty) begin
              qctl.pop  = 1'b1;
              qctl.push = 1'b1;
              next_slot = head_slot;
              run       = 1'b1;
            end
          end
        end
        KIND_YIELD: begin
          // With an empty queue the running slot comes straight back.
          reload = 1'b1;
          run    = 1'b1;
          if (nonempty) begin
            qctl.pop  = 1'b1;
            qctl.push = 1'b1;
            next_slot = head_slot;
          end
        end
        KIND_BLOCK: begin
          reload = 1'b1;
          run    = 1'b1;
          status_next[running_slot[IDX_W-1:0]] = SLOT_PARKED;
          if (nonempty) begin
            qctl.pop  = 1'b1;
            next_slot = head_slot;
          end else begin
            next_slot = idle_eff;
          end
        end
        KIND_UNBLOCK: begin
          if (req_blocked) begin
            if (!q_full) begin
              qctl.push = 1'b1;
              qctl.slot = task_req;
              status_next[task_req[IDX_W-1:0]] = SLOT_QUEUED;
            end
          end else begin
            rej = 1'b1;
          end
        end
        KIND_SETQ: begin
          if (req_ok) begin
            qtab_next[task_req[IDX_W-1:0]] = (quantum == '0) ? QUANT_W'(1) : quantum;
          end
        end
        default: begin
        end
      endcase
    end
    if (qctl.pop && qctl.push) begin
      status_next[running_slot[IDX_W-1:0]] = SLOT_QUEUED;
    end
    if (run) begin
      status_next[next_slot[IDX_W-1:0]] = SLOT_RUNNING;
    end
  end

  assign running_slot_next = run ? next_slot : running_slot;
  assign sw                = run && (next_slot != running_slot);

  always_comb begin
    countdown_next = countdown;
    if (reload) begin
      countdown_next = qtab[next_slot[IDX_W-1:0]];
    end else if (cd_dec) begin
      countdown_next = countdown - QUANT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      done         <= 1'b0;
      idle_slot    <= '0;
      running_slot <= SLOT_W'(1);
      countdown    <= RESET_QUANTUM;
      for (int k = 0; k < NSLOT; k++) begin
        status[k] <= (k == 1) ? SLOT_RUNNING : SLOT_PARKED;
        qtab[k]   <= RESET_QUANTUM;
      end
    end else begin
      busy         <= 1'b0;
      done         <= accept;
      running_slot <= running_slot_next;
      countdown    <= countdown_next;
      status       <= status_next;
      qtab         <= qtab_next;
      if (cfg_valid && cfg_ready) begin
        idle_slot <= cfg_data;
      end
    end
  end

  // Flags of the last event; the state registers already show its outcome.
  always_ff @(posedge clk) begin
    if (accept) begin
      switched <= sw;
      rejected <= rej;
    end
  end

  assign running_task = running_slot;
  assign remaining    = countdown;
  assign ready_count  = COUNT_W'(q_count);

endmodule

// ===== rtl/core/rrqs_checker.sv =====
// ----------------------------------------------------------------------------
// rrqs_checker
// Port-level checks on the scheduler: one result per transfer, and results
// that agree with the visible state before the event.
// ----------------------------------------------------------------------------
module rrqs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [rrqs_pkg::SLOT_W-1:0]   running_task,
  input logic                          done,
  input logic                          switched,
  input logic                          rejected,
  input logic [rrqs_pkg::COUNT_W-1:0]  ready_count
);
  import rrqs_pkg::*;

  // Every accepted event gives exactly one result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result after an accepted event");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without an accepted event");

  // If no switch is reported, the running slot must not have changed.
  a_switch_flag: assert property (@(posedge clk) disable iff (rst)
    (done && !switched) |-> (running_task == $past(running_task)))
    else $error("running slot changed without switched");

  // A rejected unblock leaves the queue and the running slot alone.
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && rejected) |->
      ((ready_count == $past(ready_count)) && !switched))
    else $error("rejected unblock changed the schedule");

endmodule

bind round_robin_quantum_scheduler_top rrqs_checker u_rrqs_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .running_task (running_task),
  .done         (done),
  .switched     (switched),
  .rejected     (rejected),
  .ready_count  (ready_count)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the round-robin quantum scheduler. A queue of
// scheduler events, idle-slot writes and drain points feeds a clocked driver.
// Every accepted event is run through a behavioural scheduler kept in the
// bench, and the strobed result is compared field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrqs_pkg::*;

  localparam int TASKS          = 16;
  localparam int NSLOT          = (TASKS < MAX_SLOTS) ? TASKS : MAX_SLOTS;
  localparam int PHASES         = 6;
  localparam int PHASE_EVENTS   = 100;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  typedef enum logic [1:0] {STEP_EVENT, STEP_CONFIG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t         what;
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [QUANT_W-1:0] quantum;
  } sched_step_t;

  typedef struct {
    logic [SLOT_W-1:0]  running_task;
    logic [QUANT_W-1:0] remaining;
    logic               switched;
    logic               rejected;
    logic [COUNT_W-1:0] ready_count;
  } sched_result_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  logic               busy;
  logic [KIND_W-1:0]  kind         = '0;
  logic [SLOT_W-1:0]  task_req     = '0;
  logic [QUANT_W-1:0] quantum      = '0;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [SLOT_W-1:0]  cfg_data     = '0;
  logic               done;
  logic [SLOT_W-1:0]  running_task;
  logic [QUANT_W-1:0] remaining;
  logic               switched;
  logic               rejected;
  logic [COUNT_W-1:0] ready_count;

  sched_step_t   pending_steps[$];
  sched_result_t expected_results[$];

  // Scheduler state as the bench sees it.
  logic [SLOT_W-1:0]  rq_slot [MAX_SLOTS];
  int                 rq_count;
  int                 rq_head;
  logic [1:0]         slot_state [MAX_SLOTS];
  logic [QUANT_W-1:0] slot_quantum [MAX_SLOTS];
  logic [SLOT_W-1:0]  cur_slot;
  logic [QUANT_W-1:0] ticks_left;
  logic [SLOT_W-1:0]  idle_reg;

  int gap_left;
  int calm_left;
  int settle_count;
  int quiet_cycles   = 0;
  int results_seen   = 0;
  int mismatch_count = 0;

  round_robin_quantum_scheduler_top #(
    .MAX_TASKS(TASKS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .task_req(task_req),
    .quantum(quantum),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .running_task(running_task),
    .remaining(remaining),
    .switched(switched),
    .rejected(rejected),
    .ready_count(ready_count)
  );

  initial begin
    forever #5ns clk = ~clk;
  end

  function automatic void add_step(step_kind_t what, logic [KIND_W-1:0] k,
                                   logic [SLOT_W-1:0] slot, logic [QUANT_W-1:0] q);
    sched_step_t s;
    s.what    = what;
    s.kind    = k;
    s.slot    = slot;
    s.quantum = q;
    pending_steps.push_back(s);
  endfunction

  // An append to a full queue is dropped, as the block does.
  function automatic void enqueue_slot(logic [SLOT_W-1:0] slot);
    if (rq_count < NSLOT) begin
      rq_slot[(rq_head + rq_count) % NSLOT] = slot;
      rq_count++;
      slot_state[slot] = SLOT_QUEUED;
    end
  endfunction

  // The head of the ready queue runs next; with the queue empty the idle
  // slot runs, and an idle slot beyond the last slot is taken as slot zero.
  function automatic void dispatch_next();
    logic [SLOT_W-1:0] next_slot;
    if (rq_count > 0) begin
      next_slot = rq_slot[rq_head];
      rq_head   = (rq_head + 1) % NSLOT;
      rq_count--;
    end else begin
      next_slot = (int'(idle_reg) < NSLOT) ? idle_reg : '0;
    end
    slot_state[next_slot] = SLOT_RUNNING;
    cur_slot   = next_slot;
    ticks_left = slot_quantum[next_slot];
  endfunction

  function automatic void predict_event(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] req,
                                        logic [QUANT_W-1:0] q);
    sched_result_t     r;
    logic [SLOT_W-1:0] prev_slot;
    prev_slot  = cur_slot;
    r.rejected = 1'b0;
    case (k)
      KIND_TICK: begin
        if (ticks_left <= 1) begin
          ticks_left = '0;
          if (rq_count > 0) begin
            enqueue_slot(cur_slot);
            dispatch_next();
          end else begin
            ticks_left = slot_quantum[cur_slot];
          end
        end else begin
          ticks_left = ticks_left - 1'b1;
        end
      end
      KIND_YIELD: begin
        enqueue_slot(cur_slot);
        dispatch_next();
      end
      KIND_BLOCK: begin
        slot_state[cur_slot] = SLOT_PARKED;
        dispatch_next();
      end
      KIND_UNBLOCK: begin
        if (int'(req) < NSLOT && slot_state[req] == SLOT_PARKED) begin
          enqueue_slot(req);
        end else begin
          r.rejected = 1'b1;
        end
      end
      KIND_SETQ: begin
        if (int'(req) < NSLOT) begin
          slot_quantum[req] = (q == '0) ? QUANT_W'(1) : q;
        end
      end
      default: begin
      end
    endcase
    r.running_task = cur_slot;
    r.remaining    = ticks_left;
    r.switched     = (cur_slot != prev_slot);
    r.ready_count  = COUNT_W'(rq_count);
    expected_results.push_back(r);
  endfunction

  function automatic void flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%s", what);
    end
  endfunction

  function automatic void check_field(string field, logic [QUANT_W-1:0] want,
                                      logic [QUANT_W-1:0] got);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d: %s expected %0d, got %0d",
                              results_seen, field, want, got));
    end
  endfunction

  // Driver: one event or register write in flight at a time. A drain step
  // holds the sender until every predicted result has been seen.
  always @(posedge clk) begin : drive_proc
    sched_step_t step;
    logic        ev_free;
    logic        cf_free;
    logic        next_start;
    logic        next_cfg;
    int          roll;
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left     = 0;
      calm_left    = 0;
      settle_count = 0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        rq_slot[i]      = '0;
        slot_state[i]   = SLOT_PARKED;
        slot_quantum[i] = RESET_QUANTUM;
      end
      slot_state[1] = SLOT_RUNNING;
      rq_count   = 0;
      rq_head    = 0;
      cur_slot   = SLOT_W'(1);
      ticks_left = RESET_QUANTUM;
      idle_reg   = '0;
    end else begin
      if (start && !busy) begin
        predict_event(kind, task_req, quantum);
      end
      if (cfg_valid && cfg_ready) begin
        idle_reg = cfg_data;
      end
      ev_free = !start || !busy;
      cf_free = !cfg_valid || cfg_ready;
      if (ev_free && cf_free) begin
        next_start = 1'b0;
        next_cfg   = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_steps.size() > 0) begin
          step = pending_steps[0];
          case (step.what)
            STEP_DRAIN: begin
              if (expected_results.size() == 0) begin
                settle_count++;
              end else begin
                settle_count = 0;
              end
              if (settle_count >= SETTLE_CYCLES) begin
                settle_count = 0;
                step = pending_steps.pop_front();
              end
            end
            STEP_CONFIG: begin
              step = pending_steps.pop_front();
              next_cfg = 1'b1;
              cfg_data <= step.slot;
            end
            default: begin
              step = pending_steps.pop_front();
              next_start = 1'b1;
              kind     <= step.kind;
              task_req <= step.slot;
              quantum  <= step.quantum;
              // Mostly short gaps, a few long ones, and now and then a calm
              // stretch of back-to-back transfers.
              if (calm_left > 0) begin
                calm_left--;
                gap_left = 0;
              end else begin
                roll = $urandom_range(99);
                if (roll < 2) calm_left = $urandom_range(80, 30);
                if (roll < 55) gap_left = 0;
                else if (roll < 88) gap_left = $urandom_range(3, 1);
                else if (roll < 98) gap_left = $urandom_range(12, 4);
                else gap_left = $urandom_range(60, 20);
              end
            end
          endcase
        end
        start     <= next_start;
        cfg_valid <= next_cfg;
      end
    end
  end

  always @(posedge clk) begin : check_proc
    sched_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        check_field("running_task", QUANT_W'(want.running_task), QUANT_W'(running_task));
        check_field("remaining", want.remaining, remaining);
        check_field("switched", QUANT_W'(want.switched), QUANT_W'(switched));
        check_field("rejected", QUANT_W'(want.rejected), QUANT_W'(rejected));
        check_field("ready_count", QUANT_W'(want.ready_count), QUANT_W'(ready_count));
      end
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("round_robin_quantum_scheduler_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus_proc
    int                 roll;
    int                 issued;
    logic [KIND_W-1:0]  k;
    logic [QUANT_W-1:0] q;
    logic [SLOT_W-1:0]  idle_pick;

    // Directed opening with the idle slot at zero.
    add_step(STEP_CONFIG, KIND_TICK, '0, '0);
    add_step(STEP_EVENT, KIND_TICK, '0, '0);
    add_step(STEP_EVENT, KIND_SPARE_FIRST, '1, '1);
    add_step(STEP_EVENT, KIND_SPARE_LAST, '0, '0);
    // Yield with nobody ready: the same slot carries on with a fresh quantum.
    add_step(STEP_EVENT, KIND_YIELD, '0, '0);
    // Block with an empty queue twice; the second time the idle slot blocks
    // itself and is put straight back.
    add_step(STEP_EVENT, KIND_BLOCK, '0, '0);
    add_step(STEP_EVENT, KIND_BLOCK, '0, '0);
    add_step(STEP_EVENT, KIND_UNBLOCK, SLOT_W'(1), '0);
    add_step(STEP_EVENT, KIND_UNBLOCK, SLOT_W'(1), '0);
    add_step(STEP_EVENT, KIND_UNBLOCK, '0, '0);
    add_step(STEP_EVENT, KIND_UNBLOCK, '1, '1);
    add_step(STEP_EVENT, KIND_SETQ, '1, '0);
    add_step(STEP_EVENT, KIND_SETQ, SLOT_W'(1), '1);
    add_step(STEP_EVENT, KIND_SETQ, '0, QUANT_W'(2));
    add_step(STEP_EVENT, KIND_YIELD, '0, '0);
    add_step(STEP_EVENT, KIND_YIELD, '0, '0);
    add_step(STEP_EVENT, KIND_TICK, '0, '0);
    add_step(STEP_EVENT, KIND_TICK, '0, '0);
    add_step(STEP_EVENT, KIND_TICK, '0, '0);
    add_step(STEP_EVENT, KIND_BLOCK, '0, '0);
    add_step(STEP_EVENT, KIND_BLOCK, '0, '0);
    add_step(STEP_EVENT, KIND_TICK, '0, '0);
    add_step(STEP_EVENT, KIND_TICK, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      if (p % 2 == 1) idle_pick = SLOT_W'($urandom_range(NSLOT - 1));
      else if (p == 2) idle_pick = '0;
      else idle_pick = SLOT_W'(NSLOT - 1);
      add_step(STEP_DRAIN, KIND_TICK, '0, '0);
      add_step(STEP_CONFIG, KIND_TICK, idle_pick, '0);
      issued = 0;
      while (issued < PHASE_EVENTS) begin
        roll = $urandom_range(99);
        if (roll < 38) k = KIND_TICK;
        else if (roll < 50) k = KIND_YIELD;
        else if (roll < 61) k = KIND_BLOCK;
        else if (roll < 82) k = KIND_UNBLOCK;
        else if (roll < 96) k = KIND_SETQ;
        else k = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
        // Short quanta keep expiries frequent; the extremes turn up too.
        roll = $urandom_range(99);
        if (roll < 40) q = QUANT_W'($urandom_range(4, 1));
        else if (roll < 50) q = '0;
        else if (roll < 58) q = '1;
        else if (roll < 80) q = QUANT_W'($urandom_range(20, 5));
        else q = QUANT_W'($urandom_range(16'hFFFF));
        add_step(STEP_EVENT, k, SLOT_W'($urandom_range((1 << SLOT_W) - 1)), q);
        if (k < KIND_SPARE_FIRST) issued++;
      end
    end
    add_step(STEP_DRAIN, KIND_TICK, '0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_steps.size() != 0 || start || cfg_valid ||
           expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      flag_mismatch("predicted result never arrived");
    end
    if (mismatch_count == 0) begin
      $display("round_robin_quantum_scheduler_top: match");
    end else begin
      $display("round_robin_quantum_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule
